// ===== sv/haptic_effect_sequencer_defines.svh =====
// assertion macros shared by the haptic effect sequencer modules
// expects clk and arst_n in the scope of each use
`ifndef HAPTIC_EFFECT_SEQUENCER_DEFINES_SVH
`define HAPTIC_EFFECT_SEQUENCER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define HES_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define HES_ASSERT(lbl, prop, msg)
`define HES_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/hes_pkg.sv =====
// shared types, codes and effect tables of the haptic effect sequencer
// no dependencies
package hes_pkg;

	localparam int FIFO_SLOTS_DEF  = 8;
	localparam int EFFECT_COUNT    = 6;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	// register index, taken from the word address bit
	localparam logic REG_POLARITY = 1'b0;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_PLAY   = 3'd1,
		CMD_PULSE  = 3'd2,
		CMD_CLEAR  = 3'd3,
		CMD_ENABLE = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		EFF_TICK    = 3'd0,
		EFF_CLICK   = 3'd1,
		EFF_DOUBLE  = 3'd2,
		EFF_CONFIRM = 3'd3,
		EFF_ALERT   = 3'd4,
		EFF_HEAVY   = 3'd5
	} effect_t;

	typedef struct packed {
		logic        is_pulse;
		logic [2:0]  effect;
		logic [15:0] len_ms;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_ctl_t;

	typedef struct packed {
		logic        accepted;
		logic        motor_pin;
		logic        motor_on;
		logic        busy;
		logic [3:0]  pending;
		logic [31:0] dropped;
	} res_t;

	function automatic logic [15:0] effect_seg_ms(logic [2:0] eff, logic [1:0] idx);
		logic [15:0] ms;
		ms = 16'd0;
		unique case (effect_t'(eff))
			EFF_TICK:    ms = (idx == 2'd0) ? 16'd55 : 16'd0;
			EFF_CLICK:   ms = (idx == 2'd0) ? 16'd64 : 16'd0;
			EFF_DOUBLE:  ms = (idx == 2'd0) ? 16'd36 : (idx == 2'd1) ? 16'd48 :
				(idx == 2'd2) ? 16'd36 : 16'd0;
			EFF_CONFIRM: ms = (idx == 2'd0) ? 16'd30 : (idx == 2'd1) ? 16'd35 :
				(idx == 2'd2) ? 16'd76 : 16'd0;
			EFF_ALERT:   ms = (idx == 2'd0) ? 16'd110 : (idx == 2'd1) ? 16'd65 :
				(idx == 2'd2) ? 16'd110 : 16'd0;
			EFF_HEAVY:   ms = (idx == 2'd0) ? 16'd174 : 16'd0;
			default:     ms = 16'd0;
		endcase
		return ms;
	endfunction

	function automatic logic [1:0] effect_seg_count(logic [2:0] eff);
		logic [1:0] n;
		n = 2'd0;
		unique case (effect_t'(eff))
			EFF_TICK, EFF_CLICK, EFF_HEAVY:     n = 2'd1;
			EFF_DOUBLE, EFF_CONFIRM, EFF_ALERT: n = 2'd3;
			default:                            n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [15:0] entry_seg_ms(entry_t e, logic [1:0] idx);
		return e.is_pulse ? e.len_ms : effect_seg_ms(e.effect, idx);
	endfunction

	function automatic logic entry_has_next(entry_t e, logic [1:0] idx);
		return !e.is_pulse &&
			(({1'b0, idx} + 3'd1) < {1'b0, effect_seg_count(e.effect)});
	endfunction

endpackage

// ===== sv/hes_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module hes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/hes_queue.sv =====
// first-word-fall-through queue of playable entries on top of hes_ram
// depends on hes_pkg, hes_ram and haptic_effect_sequencer_defines.svh
`include "haptic_effect_sequencer_defines.svh"
module hes_queue #(
	parameter int DEPTH  = hes_pkg::FIFO_SLOTS_DEF,
	parameter int DATA_W = hes_pkg::ENTRY_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hes_pkg::q_ctl_t   ctl,
	input  logic [DATA_W-1:0] push_data,
	output logic [DATA_W-1:0] head_data,
	output logic              nonempty
);
	import hes_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PTR_W-1:0]  rd_q, wr_q, rd_d, wr_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] byp_s1;
	logic              hit_s1;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		rd_d    = rd_q;
		wr_d    = wr_q;
		count_d = count_q;
		if (ctl.clear) begin
			rd_d    = '0;
			wr_d    = '0;
			count_d = '0;
		end else begin
			if (ctl.pop) begin
				rd_d    = ptr_inc(rd_q);
				count_d = count_q - CNT_W'(1);
			end
			if (ctl.push) begin
				wr_d    = ptr_inc(wr_q);
				count_d = count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			count_q <= count_d;
			// a write landing on the address being read is forwarded
			hit_s1  <= ctl.push && (wr_q == rd_d);
		end
	end

	always_ff @(posedge clk) begin
		byp_s1 <= push_data;
	end

	hes_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (wr_q),
		.wdata (push_data),
		.raddr (rd_d),
		.rdata (rdata)
	);

	assign head_data = hit_s1 ? byp_s1 : rdata;
	assign nonempty  = (count_q != '0);

	`HES_ASSERT_IMPL(a_pop_nonempty, ctl.pop, count_q != '0, "pop from empty queue")
	`HES_ASSERT_IMPL(a_push_room, ctl.push, count_q < CNT_W'(DEPTH), "push into full queue")
	`HES_ASSERT_IMPL(a_empty_ptrs, count_q == '0, rd_q == wr_q, "empty queue with split pointers")

endmodule

// ===== sv/hes_core.sv =====
// command decode, pending bookkeeping and segment playback of the sequencer
// depends on hes_pkg and haptic_effect_sequencer_defines.svh
`include "haptic_effect_sequencer_defines.svh"
module hes_core #(
	parameter int FIFO_SLOTS = hes_pkg::FIFO_SLOTS_DEF,
	localparam int LVL_W = $clog2(FIFO_SLOTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [2:0]       command,
	input  logic [2:0]       effect,
	input  logic [15:0]      pulse_length_ms,
	input  logic             enable_value,
	input  logic             pol_high,
	output hes_pkg::q_ctl_t  q_ctl,
	output hes_pkg::entry_t  push_entry,
	output logic [LVL_W-1:0] push_lead,
	input  logic             q_nonempty,
	input  hes_pkg::entry_t  head_entry,
	input  logic [LVL_W-1:0] head_lead,
	output hes_pkg::res_t    result
);
	import hes_pkg::*;

	localparam logic [1:0] OFF_SEG = 2'd1;

	logic             playing_q, playing_d;
	entry_t           cur_q, cur_d;
	logic [1:0]       seg_q, seg_d;
	logic [15:0]      rem_q, rem_d;
	logic             enabled_q, enabled_d;
	logic [31:0]      drop_q, drop_d;
	logic             motor_q, motor_d;
	logic [LVL_W-1:0] level_q, level_d;
	logic [LVL_W-1:0] tail_q, tail_d;
	logic             ok;
	q_ctl_t           ctl;

	always_comb begin
		logic [15:0] rem_dec;
		logic [1:0]  seg_nxt;
		entry_t      new_entry;
		logic        known;

		playing_d = playing_q;
		cur_d     = cur_q;
		seg_d     = seg_q;
		rem_d     = rem_q;
		enabled_d = enabled_q;
		drop_d    = drop_q;
		motor_d   = motor_q;
		level_d   = level_q;
		tail_d    = tail_q;
		ok        = 1'b1;
		ctl       = '0;
		rem_dec   = rem_q - 16'd1;
		seg_nxt   = seg_q + 2'd1;

		new_entry = '0;
		if (command == CMD_PULSE) begin
			new_entry.is_pulse = 1'b1;
			new_entry.len_ms   = pulse_length_ms;
		end else begin
			new_entry.effect   = effect;
		end
		// unknown effect codes end the moment they start
		known = (command == CMD_PULSE) || (effect < 3'(EFFECT_COUNT));

		unique case (cmd_t'(command))
			CMD_TICK: begin
				if (playing_q) begin
					if (rem_dec != 16'd0) begin
						rem_d = rem_dec;
					end else if (entry_has_next(cur_q, seg_q)) begin
						seg_d   = seg_nxt;
						rem_d   = entry_seg_ms(cur_q, seg_nxt);
						motor_d = (seg_nxt != OFF_SEG) && enabled_q;
					end else if (q_nonempty) begin
						// skip the dead entries ahead of the next playable one
						ctl.pop = 1'b1;
						cur_d   = head_entry;
						seg_d   = 2'd0;
						rem_d   = entry_seg_ms(head_entry, 2'd0);
						motor_d = enabled_q;
						level_d = level_q - head_lead - LVL_W'(1);
					end else begin
						playing_d = 1'b0;
						seg_d     = 2'd0;
						rem_d     = 16'd0;
						motor_d   = 1'b0;
						level_d   = '0;
						tail_d    = '0;
					end
				end
			end
			CMD_PLAY, CMD_PULSE: begin
				if (enabled_q) begin
					if ((command == CMD_PULSE) && (pulse_length_ms == 16'd0)) begin
						ok = 1'b0;
					end else if (level_q >= LVL_W'(FIFO_SLOTS)) begin
						ok     = 1'b0;
						drop_d = drop_q + 32'd1;
					end else if (!known) begin
						if (playing_q) begin
							level_d = level_q + LVL_W'(1);
							tail_d  = tail_q + LVL_W'(1);
						end
					end else if (playing_q) begin
						ctl.push = 1'b1;
						level_d  = level_q + LVL_W'(1);
						tail_d   = '0;
					end else begin
						playing_d = 1'b1;
						cur_d     = new_entry;
						seg_d     = 2'd0;
						rem_d     = entry_seg_ms(new_entry, 2'd0);
						motor_d   = 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				ctl.clear = 1'b1;
				level_d   = '0;
				tail_d    = '0;
			end
			CMD_ENABLE: begin
				enabled_d = enable_value;
				if (!enable_value) begin
					ctl.clear = 1'b1;
					level_d   = '0;
					tail_d    = '0;
					motor_d   = 1'b0;
				end
			end
			default: begin
			end
		endcase

		push_entry = new_entry;
		push_lead  = tail_q;
	end

	assign q_ctl = fire ? ctl : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			cur_q     <= '0;
			seg_q     <= 2'd0;
			rem_q     <= 16'd0;
			enabled_q <= 1'b1;
			drop_q    <= 32'd0;
			motor_q   <= 1'b0;
			level_q   <= '0;
			tail_q    <= '0;
		end else if (fire) begin
			playing_q <= playing_d;
			cur_q     <= cur_d;
			seg_q     <= seg_d;
			rem_q     <= rem_d;
			enabled_q <= enabled_d;
			drop_q    <= drop_d;
			motor_q   <= motor_d;
			level_q   <= level_d;
			tail_q    <= tail_d;
		end
	end

	always_comb begin
		result.accepted  = ok;
		result.motor_pin = (motor_d == pol_high);
		result.motor_on  = motor_d;
		result.busy      = playing_d;
		result.pending   = 4'(level_d);
		result.dropped   = drop_d;
	end

	`HES_ASSERT_IMPL(a_idle_empty, !playing_q, level_q == '0, "pending entries while idle")
	`HES_ASSERT(a_tail_le_level, tail_q <= level_q, "dead tail exceeds pending level")
	`HES_ASSERT_IMPL(a_play_time, playing_q, rem_q != 16'd0, "playing with no time left")
	`HES_ASSERT_IMPL(a_motor_play, motor_q, playing_q, "motor on with nothing playing")

endmodule

// ===== sv/haptic_effect_sequencer.sv =====
// top level of the haptic effect sequencer: config port, core, queue, result buffer
// depends on hes_pkg, hes_core and hes_queue
//
// Takes one request per clock while the skid slot is free: a millisecond tick,
// play effect, custom pulse, clear pending or set enable, and returns one
// result per request with the motor state after that request. The core
// updates its state at the accepting edge and the result lands in an output
// register, with a one-entry skid buffer so a new request is still taken while
// a result waits. Playable entries wait in a ram-based queue whose head is
// prefetched, so a finishing entry hands over to the next one in the same
// cycle. The polarity register (word address 0) sets the pin level for motor on.
module haptic_effect_sequencer #(
	parameter int FIFO_SLOTS = hes_pkg::FIFO_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  command,
	input  logic [2:0]                  effect,
	input  logic [15:0]                 pulse_length_ms,
	input  logic                        enable_value,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        accepted,
	output logic                        motor_pin,
	output logic                        motor_on,
	output logic                        busy_res,
	output logic [3:0]                  pending_count,
	output logic [31:0]                 dropped_count,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hes_pkg::PADDR_W-1:0] paddr,
	input  logic [hes_pkg::PDATA_W-1:0] pwdata,
	output logic [hes_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import hes_pkg::*;

	localparam int LVL_W  = $clog2(FIFO_SLOTS + 1);
	localparam int DATA_W = LVL_W + ENTRY_W;

	logic              pol_high_q;
	logic              fire_in, fire_out;
	q_ctl_t            q_ctl;
	entry_t            push_entry, head_entry;
	logic [LVL_W-1:0]  push_lead, head_lead;
	logic              q_nonempty;
	logic [DATA_W-1:0] head_data;
	res_t              result;
	res_t              res_q, skid_q;
	logic              out_valid_q, skid_valid_q;

	// config register, written on the access phase of a write
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_high_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_POLARITY)) begin
			pol_high_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[2] == REG_POLARITY) ? {{(PDATA_W-1){1'b0}}, pol_high_q}
		: '0;

	// handshakes: ready only drops while the skid slot is taken
	assign in_ready = !skid_valid_q;
	assign fire_in  = in_valid && in_ready;
	assign fire_out = out_valid_q && out_ready;

	hes_core #(
		.FIFO_SLOTS(FIFO_SLOTS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire_in),
		.command         (command),
		.effect          (effect),
		.pulse_length_ms (pulse_length_ms),
		.enable_value    (enable_value),
		.pol_high        (pol_high_q),
		.q_ctl           (q_ctl),
		.push_entry      (push_entry),
		.push_lead       (push_lead),
		.q_nonempty      (q_nonempty),
		.head_entry      (head_entry),
		.head_lead       (head_lead),
		.result          (result)
	);

	// each stored entry carries the count of dead entries queued ahead of it
	hes_queue #(
		.DEPTH  (FIFO_SLOTS),
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_data ({push_lead, push_entry}),
		.head_data (head_data),
		.nonempty  (q_nonempty)
	);

	assign head_entry = entry_t'(head_data[ENTRY_W-1:0]);
	assign head_lead  = head_data[DATA_W-1:ENTRY_W];

	// result register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (fire_out) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fire_in) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q  <= 1'b1;
			end
		end else if (fire_out) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (fire_out) begin
				res_q <= skid_q;
			end
		end else if (fire_in) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= result;
			end else begin
				res_q  <= result;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = res_q.accepted;
	assign motor_pin     = res_q.motor_pin;
	assign motor_on      = res_q.motor_on;
	assign busy_res      = res_q.busy;
	assign pending_count = res_q.pending;
	assign dropped_count = res_q.dropped;

endmodule
